[sv/dvru_pkg.sv]
// Shared types and constants for the distance-vector route update block.
`timescale 1ns / 1ps

package dvru_pkg;

  localparam logic [4:0] COST_INF = 5'd16;
  localparam logic [4:0] COST_ONE = 5'd1;

  localparam logic [2:0] ACT_REFRESH   = 3'd0;
  localparam logic [2:0] ACT_REPLACE   = 3'd1;
  localparam logic [2:0] ACT_UNCHANGED = 3'd2;
  localparam logic [2:0] ACT_INSERT    = 3'd3;
  localparam logic [2:0] ACT_FULL      = 3'd4;

  typedef struct packed {
    logic [31:0] neighbor_addr;
    logic [31:0] receive_if_addr;
    logic [31:0] dest_addr;
    logic [4:0]  advertised_cost;
  } in_t;

  typedef struct packed {
    logic [2:0]  action_status;
    logic [3:0]  entry_index;
    logic [4:0]  entry_cost;
    logic [31:0] entry_next_hop;
    logic [31:0] entry_interface;
  } out_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] next_hop;
    logic [31:0] intf;
    logic [4:0]  cost;
  } route_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic search_done;
    logic out_full;
  } sts_t;

endpackage

[sv/distance_vector_route_update.sv]
// Steps from accept to result: the accept cycle, then a memory read and a compare for each
// entry up to a hit or the last entry, then the decision, in which the result is committed.
// The block takes no new item until the last one is committed, since the search uses the
// table's single read port; a result word not yet taken holds the decision cycle.
// Reset (rst_n, synchronous, active low) empties the table by clearing the route count;
// entries themselves are not cleared and are only read after they were written.
`timescale 1ns / 1ps

module distance_vector_route_update #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dvru_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dvru_pkg::out_t out_data
);
  import dvru_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dvru_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  dvru_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[sv/dvru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dvru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/dvru_ctrl.sv]
// Controller state machine: accept, table search, commit.
`timescale 1ns / 1ps

module dvru_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dvru_pkg::sts_t sts,
  output dvru_pkg::cmd_t cmd
);
  import dvru_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // The result can only be written once the output word has drained.
        if (!sts.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SEARCH))
    else $error("accepted word did not start a search");

  a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state_r == ST_IDLE))
    else $error("commit did not return to idle");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.search, cmd.commit}))
    else $error("more than one command at once");

endmodule

[sv/dvru_dp.sv]
// Datapath: request register, table memory, search pipeline, decision and output word.
`timescale 1ns / 1ps

module dvru_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dvru_pkg::in_t  in_data,
  output dvru_pkg::out_t out_data,
  output logic           out_valid,
  input  logic           out_ready,
  input  dvru_pkg::cmd_t cmd,
  output dvru_pkg::sts_t sts
);
  import dvru_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = $bits(route_t);

  in_t          req_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic          sel_hit_r;
  logic [IW-1:0] sel_idx_r;
  route_t        sel_ent_r;
  out_t          out_r;
  logic          out_valid_r;

  logic [RW-1:0] rd_raw;
  route_t        rd_ent;
  logic          match;
  logic          last;
  logic          done;

  logic [5:0]    sum;
  logic [4:0]    sat_cost;
  logic          full;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  route_t        wr_ent;
  out_t          res;
  logic [IW-1:0] res_idx;
  logic [IW+3:0] res_idx_ext;
  logic          do_insert;

  dvru_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.commit && wr_en),
    .waddr(wr_idx),
    .wdata(wr_ent),
    .raddr(idx_r),
    .rdata(rd_raw)
  );

  assign rd_ent = route_t'(rd_raw);

  // Compare stage sees the entry read in the cycle before.
  assign match = cmp_vld_r && (rd_ent.dest == req_r.dest_addr);
  assign last  = cmp_vld_r && (CW'(cmp_idx_r) == (count_r - CW'(1)));
  assign done  = (count_r == '0) || match || last;

  assign sts.search_done = done;
  assign sts.out_full    = out_valid_r;

  // Decision on the selected entry.
  always_comb begin
    sum       = {1'b0, req_r.advertised_cost} + 6'd1;
    sat_cost  = (sum > {1'b0, COST_INF}) ? COST_INF : sum[4:0];
    full      = (count_r == CW'(TABLE_DEPTH));
    wr_en     = 1'b0;
    do_insert = 1'b0;
    wr_idx    = sel_idx_r;
    wr_ent    = sel_ent_r;
    res_idx   = sel_idx_r;
    res       = '0;
    if (sel_hit_r) begin
      if (sel_ent_r.next_hop == req_r.neighbor_addr) begin
        wr_en       = 1'b1;
        wr_ent.cost = sat_cost;
        res.action_status = ACT_REFRESH;
      end else if (sum < {1'b0, sel_ent_r.cost}) begin
        wr_en           = 1'b1;
        wr_ent.next_hop = req_r.neighbor_addr;
        wr_ent.intf     = req_r.receive_if_addr;
        wr_ent.cost     = sat_cost;
        res.action_status = ACT_REPLACE;
      end else begin
        res.action_status = ACT_UNCHANGED;
      end
    end else if (!full) begin
      wr_en           = 1'b1;
      do_insert       = 1'b1;
      wr_idx          = count_r[IW-1:0];
      res_idx         = count_r[IW-1:0];
      wr_ent.dest     = req_r.dest_addr;
      wr_ent.next_hop = req_r.neighbor_addr;
      wr_ent.intf     = req_r.receive_if_addr;
      wr_ent.cost     = (req_r.neighbor_addr == req_r.dest_addr) ? COST_ONE : sat_cost;
      res.action_status = ACT_INSERT;
    end else begin
      res.action_status = ACT_FULL;
    end
    res_idx_ext = (IW + 4)'(res_idx);
    if (res.action_status != ACT_FULL) begin
      res.entry_index     = res_idx_ext[3:0];
      res.entry_cost      = wr_ent.cost;
      res.entry_next_hop  = wr_ent.next_hop;
      res.entry_interface = wr_ent.intf;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      idx_r <= '0;
    end
    if (cmd.search) begin
      idx_r     <= idx_r + IW'(1);
      cmp_idx_r <= idx_r;
      if (done) begin
        sel_hit_r <= match;
        sel_idx_r <= cmp_idx_r;
        sel_ent_r <= rd_ent;
      end
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cmp_vld_r <= 1'b0;
      end else if (cmd.search) begin
        cmp_vld_r <= (CW'(idx_r) < count_r);
      end
      if (cmd.commit && do_insert) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  a_commit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid_r)
    else $error("result word overwritten before it was taken");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("route count exceeds table depth");

endmodule
